>>> rtl/core/assert_macros.svh
// assertion macros shared by the priority donation table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define PDT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define PDT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/pdt_pkg.sv
// types, codes and constants of the priority donation table
`timescale 1ns / 1ps

package pdt_pkg;

   localparam int DEFAULT_MAX_DONORS   = 8;
   localparam int DEFAULT_LOCK_ID_BITS = 8;
   localparam int PRIO_BITS            = 6;
   localparam int COUNT_OUT_BITS       = 4;
   localparam int ACTION_BITS          = 2;
   localparam int STATUS_BITS          = 2;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_SET_BASE = 2'd0,
      ACT_DONATE   = 2'd1,
      ACT_RELEASE  = 2'd2,
      ACT_QUERY    = 2'd3
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_REMOVE,
      S_SCAN,
      S_INSERT,
      S_FINISH
   } seq_state_type;

   typedef enum logic [1:0] {
      TBL_HOLD,
      TBL_REMOVE,
      TBL_INSERT
   } tbl_op_type;

   typedef enum logic {
      CMP_EQ,
      CMP_GT
   } cmp_mode_type;

   typedef struct packed {
      logic [PRIO_BITS-1:0]      effective_priority;
      logic                      donated;
      logic [COUNT_OUT_BITS-1:0] donor_count;
      status_type                status;
   } rsp_type;

endpackage

>>> rtl/core/pdt_cmp.sv
// shared compare unit: lock match or priority order against one table entry
`timescale 1ns / 1ps

module pdt_cmp import pdt_pkg::*; #(
   parameter int OW = DEFAULT_LOCK_ID_BITS,
   parameter int CW = $clog2(DEFAULT_MAX_DONORS + 1)
) (
   input  cmp_mode_type  mode,
   input  logic [OW-1:0] a,
   input  logic [OW-1:0] b,
   input  logic [CW-1:0] idx,
   input  logic [CW-1:0] count,
   output logic          hit,
   output logic          at_end
);

   always_comb begin
      at_end = (idx == count);
      unique case (mode)
         CMP_EQ:  hit = !at_end && (a == b);
         // insertion point: past the last entry or ahead of a lower priority
         CMP_GT:  hit = at_end || (a > b);
         default: hit = 1'b0;
      endcase
   end

endmodule

>>> rtl/core/pdt_table.sv
// donor entry table: sorted lock and priority registers with shift moves
`timescale 1ns / 1ps

module pdt_table import pdt_pkg::*; #(
   parameter int MAX_DONORS   = DEFAULT_MAX_DONORS,
   parameter int LOCK_ID_BITS = DEFAULT_LOCK_ID_BITS,
   parameter int IW           = (MAX_DONORS > 1) ? $clog2(MAX_DONORS) : 1
) (
   input  logic                    clock,
   input  tbl_op_type              op,
   input  logic [IW-1:0]           pos,
   input  logic [LOCK_ID_BITS-1:0] wr_lock,
   input  logic [PRIO_BITS-1:0]    wr_prio,
   input  logic [IW-1:0]           rd_idx,
   output logic [LOCK_ID_BITS-1:0] rd_lock,
   output logic [PRIO_BITS-1:0]    rd_prio,
   output logic [PRIO_BITS-1:0]    head_prio
);

   logic [LOCK_ID_BITS-1:0] lock_ff [MAX_DONORS];
   logic [LOCK_ID_BITS-1:0] lock_in [MAX_DONORS];
   logic [PRIO_BITS-1:0]    prio_ff [MAX_DONORS];
   logic [PRIO_BITS-1:0]    prio_in [MAX_DONORS];

   for (genvar k = 0; k < MAX_DONORS; k++) begin : g_entry
      logic [LOCK_ID_BITS-1:0] up_lock;
      logic [LOCK_ID_BITS-1:0] dn_lock;
      logic [PRIO_BITS-1:0]    up_prio;
      logic [PRIO_BITS-1:0]    dn_prio;

      // neighbor above feeds a removal, neighbor below feeds an insertion
      if (k < MAX_DONORS - 1) begin : g_up
         assign up_lock = lock_ff[k+1];
         assign up_prio = prio_ff[k+1];
      end else begin : g_top
         assign up_lock = lock_ff[k];
         assign up_prio = prio_ff[k];
      end
      if (k > 0) begin : g_dn
         assign dn_lock = lock_ff[k-1];
         assign dn_prio = prio_ff[k-1];
      end else begin : g_bottom
         assign dn_lock = lock_ff[k];
         assign dn_prio = prio_ff[k];
      end

      always_comb begin
         lock_in[k] = lock_ff[k];
         prio_in[k] = prio_ff[k];
         unique case (op)
            TBL_REMOVE: begin
               if (pos <= IW'(k)) begin
                  lock_in[k] = up_lock;
                  prio_in[k] = up_prio;
               end
            end
            TBL_INSERT: begin
               if (pos == IW'(k)) begin
                  lock_in[k] = wr_lock;
                  prio_in[k] = wr_prio;
               end else if (pos < IW'(k)) begin
                  lock_in[k] = dn_lock;
                  prio_in[k] = dn_prio;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      lock_ff <= lock_in;
      prio_ff <= prio_in;
   end

   assign rd_lock   = lock_ff[rd_idx];
   assign rd_prio   = prio_ff[rd_idx];
   assign head_prio = prio_ff[0];

endmodule

>>> rtl/core/pdt_seq.sv
// sequencer: walks the table through the shared compare unit, holds the result
`timescale 1ns / 1ps

module pdt_seq import pdt_pkg::*; #(
   parameter int MAX_DONORS   = DEFAULT_MAX_DONORS,
   parameter int LOCK_ID_BITS = DEFAULT_LOCK_ID_BITS,
   parameter int CW           = $clog2(MAX_DONORS + 1),
   parameter int IW           = (MAX_DONORS > 1) ? $clog2(MAX_DONORS) : 1,
   parameter int OW           = (LOCK_ID_BITS > PRIO_BITS) ? LOCK_ID_BITS : PRIO_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ACTION_BITS-1:0]  req_action,
   input  logic [LOCK_ID_BITS-1:0] req_lock_id,
   input  logic [PRIO_BITS-1:0]    req_priority_req,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp_data,
   output cmp_mode_type            cmp_mode,
   output logic [OW-1:0]           cmp_a,
   output logic [OW-1:0]           cmp_b,
   output logic [CW-1:0]           cmp_idx,
   output logic [CW-1:0]           cmp_count,
   input  logic                    cmp_hit,
   input  logic                    cmp_at_end,
   output logic [IW-1:0]           rd_idx,
   input  logic [LOCK_ID_BITS-1:0] rd_lock,
   input  logic [PRIO_BITS-1:0]    rd_prio,
   input  logic [PRIO_BITS-1:0]    head_prio,
   output tbl_op_type              tbl_op,
   output logic [IW-1:0]           tbl_pos,
   output logic [LOCK_ID_BITS-1:0] tbl_lock,
   output logic [PRIO_BITS-1:0]    tbl_prio
);

   seq_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          donated_ff, donated_in;
   logic [PRIO_BITS-1:0] base_ff, base_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   action_type              action_ff, action_in;
   logic [LOCK_ID_BITS-1:0] lock_ff, lock_in;
   logic [PRIO_BITS-1:0]    prio_ff, prio_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic [IW-1:0]           pos_ff, pos_in;
   status_type              status_ff, status_in;

   logic [PRIO_BITS-1:0] eff_prio;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         donated_ff   <= 1'b0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         donated_ff   <= donated_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      action_ff <= action_in;
      lock_ff   <= lock_in;
      prio_ff   <= prio_in;
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
   end

   assign eff_prio = (donated_ff && (count_ff != '0)) ? head_prio : base_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      donated_in   = donated_ff;
      base_in      = base_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      action_in    = action_ff;
      lock_in      = lock_ff;
      prio_in      = prio_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      status_in    = status_ff;

      req_ready = 1'b0;
      cmp_mode  = CMP_EQ;
      cmp_a     = OW'(rd_lock);
      cmp_b     = OW'(lock_ff);
      tbl_op    = TBL_HOLD;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               action_in = action_type'(req_action);
               lock_in   = req_lock_id;
               prio_in   = req_priority_req;
               idx_in    = '0;
               status_in = ST_OK;
               unique case (action_type'(req_action))
                  ACT_SET_BASE: begin
                     base_in  = req_priority_req;
                     state_in = S_FINISH;
                  end
                  ACT_DONATE: state_in = S_FIND;
                  ACT_RELEASE: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_FINISH;
                     end else begin
                        state_in = S_FIND;
                     end
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_FIND: begin
            if (cmp_hit) begin
               pos_in   = idx_ff[IW-1:0];
               state_in = S_REMOVE;
            end else if (cmp_at_end) begin
               if (action_ff == ACT_DONATE) begin
                  if (count_ff == CW'(MAX_DONORS)) begin
                     status_in = ST_FULL;
                     state_in  = S_FINISH;
                  end else begin
                     idx_in   = '0;
                     state_in = S_SCAN;
                  end
               end else begin
                  status_in = ST_NOT_FOUND;
                  state_in  = S_FINISH;
               end
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         S_REMOVE: begin
            tbl_op   = TBL_REMOVE;
            count_in = count_ff - CW'(1);
            if (action_ff == ACT_DONATE) begin
               // a repeated lock is taken out and put back in sorted place
               idx_in   = '0;
               state_in = S_SCAN;
            end else begin
               if (count_ff == CW'(1)) begin
                  donated_in = 1'b0;
               end
               state_in = S_FINISH;
            end
         end
         S_SCAN: begin
            cmp_mode = CMP_GT;
            cmp_a    = OW'(prio_ff);
            cmp_b    = OW'(rd_prio);
            if (cmp_hit) begin
               pos_in   = idx_ff[IW-1:0];
               state_in = S_INSERT;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         S_INSERT: begin
            tbl_op     = TBL_INSERT;
            count_in   = count_ff + CW'(1);
            donated_in = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.effective_priority = eff_prio;
               rsp_in.donated            = donated_ff;
               rsp_in.donor_count        = COUNT_OUT_BITS'(count_ff);
               rsp_in.status             = status_ff;
               rsp_valid_in              = 1'b1;
               state_in                  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign cmp_idx   = idx_ff;
   assign cmp_count = count_ff;
   assign rd_idx    = idx_ff[IW-1:0];
   assign tbl_pos   = pos_ff;
   assign tbl_lock  = lock_ff;
   assign tbl_prio  = prio_ff;

endmodule

>>> rtl/core/priority_donation_table.sv
// top level of the priority donation table
//
//   channel   direction  ports                                             handshake
//   req       in         req_action, req_lock_id, req_priority_req          req_valid/req_ready
//   rsp       out        rsp_effective_priority, rsp_donated,
//                        rsp_donor_count, rsp_status                       rsp_valid/rsp_ready
//
// one transaction at a time; req_ready is high only while the sequencer is idle.
// rsp_valid is set from the finish step; set-base and query go straight there, release
// searches the held entries and donate also scans for its place: one compare per entry.
// a low rsp_ready holds the sequencer in its finish step until the result register frees.
// the result register holds the last answer while a new transaction is taken.
// reset clears counts, flags and base priority; table entries need no clearing.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module priority_donation_table import pdt_pkg::*; #(
   parameter int MAX_DONORS   = DEFAULT_MAX_DONORS,
   parameter int LOCK_ID_BITS = DEFAULT_LOCK_ID_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [ACTION_BITS-1:0]    req_action,
   input  logic [LOCK_ID_BITS-1:0]   req_lock_id,
   input  logic [PRIO_BITS-1:0]      req_priority_req,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [PRIO_BITS-1:0]      rsp_effective_priority,
   output logic                      rsp_donated,
   output logic [COUNT_OUT_BITS-1:0] rsp_donor_count,
   output logic [STATUS_BITS-1:0]    rsp_status
);

   localparam int CW = $clog2(MAX_DONORS + 1);
   localparam int IW = (MAX_DONORS > 1) ? $clog2(MAX_DONORS) : 1;
   localparam int OW = (LOCK_ID_BITS > PRIO_BITS) ? LOCK_ID_BITS : PRIO_BITS;

   rsp_type                 rsp_data;
   cmp_mode_type            cmp_mode;
   logic [OW-1:0]           cmp_a;
   logic [OW-1:0]           cmp_b;
   logic [CW-1:0]           cmp_idx;
   logic [CW-1:0]           cmp_count;
   logic                    cmp_hit;
   logic                    cmp_at_end;
   logic [IW-1:0]           rd_idx;
   logic [LOCK_ID_BITS-1:0] rd_lock;
   logic [PRIO_BITS-1:0]    rd_prio;
   logic [PRIO_BITS-1:0]    head_prio;
   tbl_op_type              tbl_op;
   logic [IW-1:0]           tbl_pos;
   logic [LOCK_ID_BITS-1:0] tbl_lock;
   logic [PRIO_BITS-1:0]    tbl_prio;

   pdt_seq #(
      .MAX_DONORS   (MAX_DONORS),
      .LOCK_ID_BITS (LOCK_ID_BITS),
      .CW           (CW),
      .IW           (IW),
      .OW           (OW)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_lock_id      (req_lock_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .cmp_mode         (cmp_mode),
      .cmp_a            (cmp_a),
      .cmp_b            (cmp_b),
      .cmp_idx          (cmp_idx),
      .cmp_count        (cmp_count),
      .cmp_hit          (cmp_hit),
      .cmp_at_end       (cmp_at_end),
      .rd_idx           (rd_idx),
      .rd_lock          (rd_lock),
      .rd_prio          (rd_prio),
      .head_prio        (head_prio),
      .tbl_op           (tbl_op),
      .tbl_pos          (tbl_pos),
      .tbl_lock         (tbl_lock),
      .tbl_prio         (tbl_prio)
   );

   pdt_cmp #(
      .OW (OW),
      .CW (CW)
   ) u_cmp (
      .mode   (cmp_mode),
      .a      (cmp_a),
      .b      (cmp_b),
      .idx    (cmp_idx),
      .count  (cmp_count),
      .hit    (cmp_hit),
      .at_end (cmp_at_end)
   );

   pdt_table #(
      .MAX_DONORS   (MAX_DONORS),
      .LOCK_ID_BITS (LOCK_ID_BITS),
      .IW           (IW)
   ) u_table (
      .clock     (clock),
      .op        (tbl_op),
      .pos       (tbl_pos),
      .wr_lock   (tbl_lock),
      .wr_prio   (tbl_prio),
      .rd_idx    (rd_idx),
      .rd_lock   (rd_lock),
      .rd_prio   (rd_prio),
      .head_prio (head_prio)
   );

   assign rsp_effective_priority = rsp_data.effective_priority;
   assign rsp_donated            = rsp_data.donated;
   assign rsp_donor_count        = rsp_data.donor_count;
   assign rsp_status             = rsp_data.status;

   `PDT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready,
      "sequencer still idle after taking a transaction")
   `PDT_ASSERT_NOW(a_full_keeps_donation, rsp_valid && rsp_status == ST_FULL, rsp_donated,
      "table full reported while no donation is held")
   `PDT_ASSERT_NOW(a_empty_release_clean,
      rsp_valid && rsp_status == ST_EMPTY, !rsp_donated && rsp_donor_count == '0,
      "empty release reported with entries held")

endmodule

>>> verif/tb_priority_donation_table.sv
// self-checking testbench of the priority donation table
`timescale 1ns / 1ps

module tb_priority_donation_table;
   import pdt_pkg::*;

   localparam int DONOR_SLOTS  = DEFAULT_MAX_DONORS;
   localparam int SCRIPT_ROWS  = 25;
   localparam int RANDOM_ITEMS = 2000;
   localparam int QUIET_ITEMS  = 300;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [ACTION_BITS-1:0]    req_action = ACT_QUERY;
   logic [7:0]                req_lock_id = '0;
   logic [PRIO_BITS-1:0]      req_priority_req = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [PRIO_BITS-1:0]      rsp_effective_priority;
   logic                      rsp_donated;
   logic [COUNT_OUT_BITS-1:0] rsp_donor_count;
   logic [STATUS_BITS-1:0]    rsp_status;

   typedef struct packed {
      logic [7:0]           lock;
      logic [PRIO_BITS-1:0] prio;
   } donor_entry_type;

   typedef struct packed {
      action_type                act;
      logic [7:0]                lock;
      logic [PRIO_BITS-1:0]      prio;
      logic                      typed;
      logic [PRIO_BITS-1:0]      eff;
      logic                      don;
      logic [COUNT_OUT_BITS-1:0] cnt;
      status_type                st;
   } script_row_type;

   // directed rows; typed answers only where they are obvious
   script_row_type script [SCRIPT_ROWS] = '{
      '{ACT_QUERY,    8'hA5, 6'h2A, 1'b1, 6'd0,  1'b0, 4'd0, ST_OK},
      '{ACT_RELEASE,  8'd0,  6'd0,  1'b1, 6'd0,  1'b0, 4'd0, ST_EMPTY},
      '{ACT_SET_BASE, 8'd0,  6'd63, 1'b1, 6'd63, 1'b0, 4'd0, ST_OK},
      '{ACT_DONATE,   8'd0,  6'd0,  1'b1, 6'd0,  1'b1, 4'd1, ST_OK},
      '{ACT_DONATE,   8'd255,6'd63, 1'b1, 6'd63, 1'b1, 4'd2, ST_OK},
      '{ACT_RELEASE,  8'd7,  6'd0,  1'b1, 6'd63, 1'b1, 4'd2, ST_NOT_FOUND},
      '{ACT_DONATE,   8'd255,6'd10, 1'b0, 6'd0,  1'b0, 4'd0, ST_OK},
      '{ACT_DONATE,   8'd1,  6'd10, 1'b0, 6'd0,  1'b0, 4'd0, ST_OK},
      '{ACT_DONATE,   8'd2,  6'd40, 1'b0, 6'd0,  1'b0, 4'd0, ST_OK},
      '{ACT_DONATE,   8'd3,  6'd0,  1'b0, 6'd0,  1'b0, 4'd0, ST_OK},
      '{ACT_DONATE,   8'd4,  6'd63, 1'b0, 6'd0,  1'b0, 4'd0, ST_OK},
      '{ACT_DONATE,   8'd5,  6'd21, 1'b0, 6'd0,  1'b0, 4'd0, ST_OK},
      '{ACT_DONATE,   8'd6,  6'd42, 1'b0, 6'd0,  1'b0, 4'd0, ST_OK},
      '{ACT_DONATE,   8'd200,6'd50, 1'b1, 6'd63, 1'b1, 4'd8, ST_FULL},
      '{ACT_DONATE,   8'd4,  6'd1,  1'b0, 6'd0,  1'b0, 4'd0, ST_OK},
      '{ACT_DONATE,   8'd170,6'd63, 1'b0, 6'd0,  1'b0, 4'd0, ST_OK},
      '{ACT_SET_BASE, 8'd90, 6'd5,  1'b0, 6'd0,  1'b0, 4'd0, ST_OK},
      '{ACT_RELEASE,  8'd255,6'd33, 1'b0, 6'd0,  1'b0, 4'd0, ST_OK},
      '{ACT_RELEASE,  8'd0,  6'd63, 1'b0, 6'd0,  1'b0, 4'd0, ST_OK},
      '{ACT_RELEASE,  8'd1,  6'd0,  1'b0, 6'd0,  1'b0, 4'd0, ST_OK},
      '{ACT_RELEASE,  8'd2,  6'd0,  1'b0, 6'd0,  1'b0, 4'd0, ST_OK},
      '{ACT_RELEASE,  8'd3,  6'd0,  1'b0, 6'd0,  1'b0, 4'd0, ST_OK},
      '{ACT_RELEASE,  8'd4,  6'd0,  1'b0, 6'd0,  1'b0, 4'd0, ST_OK},
      '{ACT_RELEASE,  8'd5,  6'd0,  1'b0, 6'd0,  1'b0, 4'd0, ST_OK},
      '{ACT_RELEASE,  8'd6,  6'd0,  1'b1, 6'd5,  1'b0, 4'd0, ST_OK}
   };

   // model of the donor record
   donor_entry_type      donor_list[$];
   logic [PRIO_BITS-1:0] base_level = '0;
   logic                 held_flag = 1'b0;

   rsp_type expected_answers[$];
   int      error_count = 0;
   bit      quiet = 1'b0;

   priority_donation_table uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_action             (req_action),
      .req_lock_id            (req_lock_id),
      .req_priority_req       (req_priority_req),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_effective_priority (rsp_effective_priority),
      .rsp_donated            (rsp_donated),
      .rsp_donor_count        (rsp_donor_count),
      .rsp_status             (rsp_status)
   );

   always #5 clock = ~clock;

   function automatic rsp_type apply_request(input action_type act, input logic [7:0] lk,
                                             input logic [PRIO_BITS-1:0] pr);
      rsp_type         answer;
      donor_entry_type fresh;
      int              hit;
      int              slot;
      answer.status = ST_OK;
      hit = -1;
      foreach (donor_list[i])
         if (hit < 0 && donor_list[i].lock == lk) hit = i;
      case (act)
         ACT_SET_BASE: base_level = pr;
         ACT_DONATE: begin
            if (hit >= 0 || donor_list.size() < DONOR_SLOTS) begin
               if (hit >= 0) donor_list.delete(hit);
               // equal priorities keep arrival order
               slot = 0;
               while (slot < donor_list.size() && !(pr > donor_list[slot].prio)) slot++;
               fresh.lock = lk;
               fresh.prio = pr;
               donor_list.insert(slot, fresh);
               held_flag = 1'b1;
            end else begin
               answer.status = ST_FULL;
            end
         end
         ACT_RELEASE: begin
            if (donor_list.size() == 0) begin
               answer.status = ST_EMPTY;
            end else if (hit < 0) begin
               answer.status = ST_NOT_FOUND;
            end else begin
               donor_list.delete(hit);
               if (donor_list.size() == 0) held_flag = 1'b0;
            end
         end
         default: ;
      endcase
      answer.effective_priority = (held_flag && donor_list.size() > 0) ?
                                  donor_list[0].prio : base_level;
      answer.donated     = held_flag;
      answer.donor_count = COUNT_OUT_BITS'(donor_list.size());
      return answer;
   endfunction

   task automatic log_fault(input string what, input int want, input int got);
      error_count++;
      if (error_count <= 10)
         $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $time);
   endtask

   // holds valid until the transaction is taken; valid stays high afterwards
   task automatic offer_request(input action_type act, input logic [7:0] lk,
                                input logic [PRIO_BITS-1:0] pr);
      req_valid        <= 1'b1;
      req_action       <= act;
      req_lock_id      <= lk;
      req_priority_req <= pr;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_answers();
      req_valid <= 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_answers.size() == 0) begin
            log_fault("pending transactions", 1, 0);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_effective_priority !== want.effective_priority)
               log_fault("effective_priority", int'(want.effective_priority),
                         int'(rsp_effective_priority));
            if (rsp_donated !== want.donated)
               log_fault("donated", int'(want.donated), int'(rsp_donated));
            if (rsp_donor_count !== want.donor_count)
               log_fault("donor_count", int'(want.donor_count), int'(rsp_donor_count));
            if (rsp_status !== want.status)
               log_fault("status", int'(want.status), int'(rsp_status));
         end
      end
   end

   // receiver stalls in bursts, with calm stretches between
   initial begin : rsp_pacing
      int stall_left;
      int calm_left;
      stall_left = 0;
      calm_left = 0;
      forever begin
         @(posedge clock);
         if (calm_left > 0) calm_left--;
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet && calm_left == 0 && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 14);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet && calm_left == 0 && $urandom_range(0, 63) == 0)
               calm_left = $urandom_range(50, 300);
         end
      end
   end

   initial begin : stimulus
      rsp_type              predicted;
      action_type           act;
      logic [7:0]           lk;
      logic [PRIO_BITS-1:0] pr;
      logic [7:0]           pool_base;
      int                   donate_cut;
      int                   pick;
      bit                   calm;
      pool_base = '0;
      donate_cut = 45;
      calm = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int row = 0; row < SCRIPT_ROWS; row++) begin
         offer_request(script[row].act, script[row].lock, script[row].prio);
         predicted = apply_request(script[row].act, script[row].lock, script[row].prio);
         if (script[row].typed)
            expected_answers.push_back({script[row].eff, script[row].don,
                                        script[row].cnt, script[row].st});
         else
            expected_answers.push_back(predicted);
         if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 15));
      end
      drain_answers();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
         if (n % 100 == 0) begin
            // each block leans toward filling, draining or a mix, on a few locks
            pick = $urandom_range(0, 2);
            donate_cut = (pick == 0) ? 60 : (pick == 1) ? 25 : 45;
            pool_base = 8'($urandom_range(0, 255));
            calm = ($urandom_range(0, 3) == 0);
            if (!quiet && $urandom_range(0, 2) == 0) drain_answers();
         end

         pick = $urandom_range(0, 99);
         if (pick < donate_cut) act = ACT_DONATE;
         else if (pick < 80) act = ACT_RELEASE;
         else if (pick < 91) act = ACT_SET_BASE;
         else act = ACT_QUERY;
         if ($urandom_range(0, 6) == 0) lk = 8'($urandom_range(0, 255));
         else lk = 8'(pool_base + $urandom_range(0, 11));
         // a coarse priority grid now and then forces ties
         if ($urandom_range(0, 3) == 0) pr = PRIO_BITS'($urandom_range(0, 3) * 21);
         else pr = PRIO_BITS'($urandom_range(0, 63));

         if (!quiet && !calm && $urandom_range(0, 4) == 0) idle_sender($urandom_range(1, 15));
         offer_request(act, lk, pr);
         expected_answers.push_back(apply_request(act, lk, pr));
      end

      drain_answers();
      repeat (40) @(posedge clock);
      if (error_count == 0 && expected_answers.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/pdt_pkg.sv
rtl/core/pdt_cmp.sv
rtl/core/pdt_table.sv
rtl/core/pdt_seq.sv
rtl/core/priority_donation_table.sv
verif/tb_priority_donation_table.sv
